// File: sv/tcpp_pkg.sv
// shared types, register codes and pixel classification for the pixel packer
package tcpp_pkg;

  localparam int MAX_ROW_PIXELS_DEF = 4096;
  localparam int QUEUE_DEPTH_DEF    = 4;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 13;

  localparam logic [CFG_INDEX_W-1:0] REG_THRESHOLD  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_ROW_PIXELS = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_PAD_COUNT  = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_PAD_VALUE  = 2'd3;

  localparam logic [7:0]  THRESHOLD_RST  = 8'h7F;
  localparam logic [12:0] ROW_PIXELS_RST = 13'd1600;
  localparam logic [1:0]  PAD_COUNT_RST  = 2'd2;
  localparam logic [7:0]  PAD_VALUE_RST  = 8'h00;

  localparam logic [1:0] CODE_OTHER = 2'h0;
  localparam logic [1:0] CODE_WHITE = 2'h1;
  localparam logic [1:0] CODE_RED   = 2'h2;
  localparam logic [1:0] CODE_BLACK = 2'h3;

  // one finished byte plus the number of pad bytes that follow it
  typedef struct packed {
    logic [7:0] data;
    logic [1:0] pads;
  } tcpp_job_t;

  typedef struct packed {
    logic empty;
    logic full;
  } tcpp_q_stat_t;

  function automatic logic [1:0] classify(input logic [7:0] b, input logic [7:0] g,
                                          input logic [7:0] r, input logic [7:0] thr);
    logic bb;
    logic gb;
    logic rb;
    logic [1:0] code;
    bb = b > thr;
    gb = g > thr;
    rb = r > thr;
    if (bb && gb && rb) begin
      code = CODE_WHITE;
    end else if (!bb && !gb && rb) begin
      code = CODE_RED;
    end else if (!bb && !gb && !rb) begin
      code = CODE_BLACK;
    end else begin
      code = CODE_OTHER;
    end
    return code;
  endfunction

endpackage

// File: sv/tcpp_front.sv
// front end: classifies pixels, packs four codes per byte, tracks row position
module tcpp_front import tcpp_pkg::*; #(
  parameter int MAX_ROW_PIXELS = MAX_ROW_PIXELS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_stall,
  input  logic [7:0]   blue,
  input  logic [7:0]   green,
  input  logic [7:0]   red,
  input  logic [7:0]   threshold,
  input  logic [12:0]  row_pixels,
  input  logic [1:0]   pad_count,
  input  tcpp_q_stat_t q_stat,
  output logic         push,
  output tcpp_job_t    push_job
);

  localparam int PW = ($clog2(MAX_ROW_PIXELS + 1) > 13) ? $clog2(MAX_ROW_PIXELS + 1) : 13;
  localparam int CW = (MAX_ROW_PIXELS / 4 > 1) ? $clog2(MAX_ROW_PIXELS / 4) : 1;
  localparam logic [PW-1:0] MAX_PIX = PW'(MAX_ROW_PIXELS);

  logic [1:0]    pixel_slot;
  logic [7:0]    pack_byte;
  logic [CW-1:0] group_count;

  logic          accept;
  logic [1:0]    code;
  logic [7:0]    byte_new;
  logic [PW-1:0] pixels;
  logic [PW-1:0] groups;
  logic          row_end;

  assign in_stall = q_stat.full;
  assign accept   = in_valid && !in_stall;
  assign code     = classify(blue, green, red, threshold);
  assign byte_new = pack_byte | (8'(code) << {pixel_slot, 1'b0});

  // oversized rows saturate
  assign pixels  = (PW'(row_pixels) > MAX_PIX) ? MAX_PIX : PW'(row_pixels);
  assign groups  = pixels >> 2;
  assign row_end = (groups != '0) && ((PW'(group_count) + PW'(1)) >= groups);

  assign push          = accept && (pixel_slot == 2'd3);
  assign push_job.data = byte_new;
  assign push_job.pads = row_end ? pad_count : 2'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_slot  <= '0;
      pack_byte   <= '0;
      group_count <= '0;
    end else if (accept) begin
      if (pixel_slot == 2'd3) begin
        pixel_slot <= '0;
        pack_byte  <= '0;
        if (groups != '0) begin
          group_count <= row_end ? '0 : group_count + CW'(1);
        end
      end else begin
        pixel_slot <= pixel_slot + 2'd1;
        pack_byte  <= byte_new;
      end
    end
  end

endmodule

// File: sv/tcpp_queue.sv
// small job queue between front end and nibble sender
module tcpp_queue import tcpp_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  tcpp_job_t    push_job,
  input  logic         pop,
  output tcpp_job_t    head,
  output tcpp_q_stat_t q_stat
);

  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int NW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [AW-1:0] LAST_ADDR = AW'(QUEUE_DEPTH - 1);

  tcpp_job_t     entries [QUEUE_DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [NW-1:0] fill;

  assign head         = entries[rd_ptr];
  assign q_stat.empty = (fill == '0);
  assign q_stat.full  = (fill == NW'(QUEUE_DEPTH));

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_ADDR) ? '0 : wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_ADDR) ? '0 : rd_ptr + AW'(1);
      end
      if (push && !pop) begin
        fill <= fill + NW'(1);
      end else if (pop && !push) begin
        fill <= fill - NW'(1);
      end
    end
  end

endmodule

// File: sv/tcpp_back.sv
// back end: splits bytes into high and low nibbles, adds row padding
module tcpp_back import tcpp_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  tcpp_job_t    head,
  input  tcpp_q_stat_t q_stat,
  output logic         pop,
  input  logic [7:0]   pad_value,
  output logic         out_valid,
  input  logic         out_stall,
  output logic [3:0]   nibble,
  output logic         byte_end,
  output logic         is_padding,
  output logic         last
);

  typedef enum logic [2:0] {
    BK_IDLE = 3'b001,
    BK_HI   = 3'b010,
    BK_LO   = 3'b100
  } tcpp_bk_state_t;

  tcpp_bk_state_t state;
  tcpp_bk_state_t state_next;
  logic [7:0]     cur_byte;
  logic           cur_pad;
  logic [1:0]     pads_left;
  logic           can_load;

  assign can_load = !out_valid || !out_stall;

  always_comb begin
    pop        = 1'b0;
    state_next = state;
    unique case (state)
      BK_IDLE: begin
        if (!q_stat.empty) begin
          pop        = 1'b1;
          state_next = BK_HI;
        end
      end
      BK_HI: begin
        if (can_load) begin
          state_next = BK_LO;
        end
      end
      BK_LO: begin
        if (can_load) begin
          if (pads_left != 2'd0) begin
            state_next = BK_HI;
          end else if (!q_stat.empty) begin
            pop        = 1'b1;
            state_next = BK_HI;
          end else begin
            state_next = BK_IDLE;
          end
        end
      end
      default: begin
        state_next = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (can_load) begin
        out_valid <= (state == BK_HI) || (state == BK_LO);
      end
    end
  end

  // current byte and output payload
  always_ff @(posedge clk) begin
    if (pop) begin
      cur_byte  <= head.data;
      cur_pad   <= 1'b0;
      pads_left <= head.pads;
    end else if (state == BK_LO && can_load && pads_left != 2'd0) begin
      cur_byte  <= pad_value;
      cur_pad   <= 1'b1;
      pads_left <= pads_left - 2'd1;
    end
    if (can_load && state == BK_HI) begin
      nibble     <= cur_byte[7:4];
      byte_end   <= 1'b0;
      is_padding <= cur_pad;
      last       <= 1'b0;
    end else if (can_load && state == BK_LO) begin
      nibble     <= cur_byte[3:0];
      byte_end   <= 1'b1;
      is_padding <= cur_pad;
      last       <= (pads_left == 2'd0);
    end
  end

endmodule

// File: sv/three_color_pixel_packer_qspi.sv
// top level of the three-color pixel packer with qspi nibble output
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  pixel   | in_valid, in_stall, blue, green, red      | in
//  nibble  | out_valid, out_stall, nibble, byte_end,   | out
//          | is_padding, last                          |
//  config  | cfg_write, cfg_index, cfg_data            | in
//
// one pixel transaction per cycle is taken while the job queue has room
// every fourth pixel completes a byte that leaves as 2 nibbles, plus 2 per pad
// byte at a row end; the nibble sender puts out one nibble per cycle while not stalled
// in_stall rises only when the job queue is full; out_stall holds the output
// register and lets the queue absorb nibble bursts
// rst is synchronous: control state clears, config returns to defaults
module three_color_pixel_packer_qspi import tcpp_pkg::*; #(
  parameter int MAX_ROW_PIXELS = MAX_ROW_PIXELS_DEF,
  parameter int QUEUE_DEPTH    = QUEUE_DEPTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [7:0]             blue,
  input  logic [7:0]             green,
  input  logic [7:0]             red,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [3:0]             nibble,
  output logic                   byte_end,
  output logic                   is_padding,
  output logic                   last
);

  // configuration registers
  logic [7:0]  threshold;
  logic [12:0] row_pixels;
  logic [1:0]  pad_count;
  logic [7:0]  pad_value;

  // front to queue to back
  logic         push;
  tcpp_job_t    push_job;
  logic         pop;
  tcpp_job_t    head;
  tcpp_q_stat_t q_stat;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold  <= THRESHOLD_RST;
      row_pixels <= ROW_PIXELS_RST;
      pad_count  <= PAD_COUNT_RST;
      pad_value  <= PAD_VALUE_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_THRESHOLD:  threshold  <= cfg_data[7:0];
        REG_ROW_PIXELS: row_pixels <= cfg_data[12:0];
        REG_PAD_COUNT:  pad_count  <= cfg_data[1:0];
        REG_PAD_VALUE:  pad_value  <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  // classify and pack, decide padding at row end
  tcpp_front #(
    .MAX_ROW_PIXELS(MAX_ROW_PIXELS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .blue      (blue),
    .green     (green),
    .red       (red),
    .threshold (threshold),
    .row_pixels(row_pixels),
    .pad_count (pad_count),
    .q_stat    (q_stat),
    .push      (push),
    .push_job  (push_job)
  );

  // finished bytes wait here while the sender is busy
  tcpp_queue #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_job(push_job),
    .pop     (pop),
    .head    (head),
    .q_stat  (q_stat)
  );

  // nibble sender with registered output
  tcpp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .q_stat    (q_stat),
    .pop       (pop),
    .pad_value (pad_value),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .nibble    (nibble),
    .byte_end  (byte_end),
    .is_padding(is_padding),
    .last      (last)
  );

endmodule

// File: sv/tcpp_checker.sv
// port-level checks for the pixel packer and their binding
module tcpp_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_stall,
  input logic [3:0] nibble,
  input logic       byte_end,
  input logic       is_padding,
  input logic       last
);

  // set after a high nibble went out, so a low nibble is due next
  logic low_due;

  always_ff @(posedge clk) begin
    if (rst) begin
      low_due <= 1'b0;
    end else if (out_valid && !out_stall) begin
      low_due <= !byte_end;
    end
  end

  a_held: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(nibble) && $stable(byte_end)
      && $stable(is_padding) && $stable(last))
    else $error("output transaction changed while stalled");

  a_low_follows_high: assert property (@(posedge clk) disable iff (rst)
    out_valid && low_due |-> byte_end)
    else $error("high nibble not followed by low nibble");

  a_high_first: assert property (@(posedge clk) disable iff (rst)
    out_valid && !low_due |-> !byte_end)
    else $error("low nibble without preceding high nibble");

  a_last_on_byte_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && last |-> byte_end)
    else $error("last flagged on a high nibble");

  a_quiet_after_reset: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("output valid right after reset");

endmodule

bind three_color_pixel_packer_qspi tcpp_checker u_tcpp_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .nibble    (nibble),
  .byte_end  (byte_end),
  .is_padding(is_padding),
  .last      (last)
);
